FILE: sv/rso_pkg.sv
// Shared types, codes and helpers for the string operation engine.
package rso_pkg;

   localparam logic MODE_BEGIN = 1'b0;
   localparam logic MODE_DATA  = 1'b1;

   localparam logic [2:0] OP_MOVS = 3'd0;
   localparam logic [2:0] OP_STOS = 3'd1;
   localparam logic [2:0] OP_LODS = 3'd2;
   localparam logic [2:0] OP_SCAS = 3'd3;
   localparam logic [2:0] OP_CMPS = 3'd4;

   localparam logic [1:0] REP_NONE = 2'd0;
   localparam logic [1:0] REP_E    = 2'd1;
   localparam logic [1:0] REP_NE   = 2'd2;
   localparam logic [1:0] REP_BAD  = 2'd3;

   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;
   localparam logic [1:0] SIZE_QWORD = 2'd3;

   typedef struct packed {
      logic        mode;
      logic [2:0]  op_kind;
      logic [1:0]  size_code;
      logic [1:0]  rep_kind;
      logic        direction;
      logic [63:0] count;
      logic [63:0] src_addr;
      logic [63:0] dst_addr;
      logic [63:0] accumulator;
      logic [63:0] src_data;
      logic [63:0] dst_data;
      logic        fault;
   } rso_req_type;

   typedef struct packed {
      logic        write_enable;
      logic [63:0] write_addr;
      logic [63:0] write_data;
      logic [63:0] next_src;
      logic [63:0] next_dst;
      logic [63:0] count_left;
      logic [63:0] acc_value;
      logic [63:0] difference;
      logic        zero_flag;
      logic        done_res;
      logic        faulted;
   } rso_rsp_type;

   typedef struct packed {
      logic [2:0] op;
      logic [1:0] size;
      logic [1:0] rep;
      logic       dir;
      logic       busy;
   } rso_ctrl_type;

   function automatic logic [63:0] size_mask(input logic [1:0] size);
      logic [63:0] m;
      unique case (size)
         SIZE_BYTE:  m = 64'h0000_0000_0000_00FF;
         SIZE_WORD:  m = 64'h0000_0000_0000_FFFF;
         SIZE_DWORD: m = 64'h0000_0000_FFFF_FFFF;
         SIZE_QWORD: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

endpackage

FILE: sv/rso_channels.sv
// Valid/ready channel interfaces for request and response transfers.
interface rso_req_if import rso_pkg::*; ();
   logic        valid;
   logic        ready;
   rso_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rso_rsp_if import rso_pkg::*; ();
   logic        valid;
   logic        ready;
   rso_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/rep_string_op_engine.sv
// Top level of the x86 string operation engine (MOVS/STOS/LODS/SCAS/CMPS).
//
// Usage:
//   req_chan carries one item per transfer. mode = begin loads a new
//   instruction (operation, size, prefix, direction, count, addresses,
//   accumulator); mode = data delivers one iteration's memory words or a
//   fault. Every request transfer yields exactly one response on rsp_chan:
//   the store request, next addresses, remaining count, accumulator,
//   difference, zero flag, done and fault status.
//   The response of an accepted item is registered and valid from the
//   cycle after its transfer. Throughput is one item per cycle while the
//   receiver takes each response, set by the single pass from the state
//   registers and request payload through the address steps and one
//   64-bit subtract and compare into the state and result registers.
//   Reset (synchronous, active high) clears the instruction state to zero
//   and idle and empties the result register.
//   When the receiver stalls, the result register holds its response and
//   req_chan.ready drops until that response is taken; a new request is
//   accepted in the same cycle that the held response transfers.
module rep_string_op_engine import rso_pkg::*; #(
   parameter int ADDR_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   rso_req_if.sink     req_chan,
   rso_rsp_if.source   rsp_chan
);

   // instruction state
   rso_ctrl_type         ctrl_ff, ctrl_in;
   logic [63:0]          remaining_ff, remaining_in;
   logic [63:0]          acc_ff, acc_in;
   logic [ADDR_BITS-1:0] src_ff, src_in;
   logic [ADDR_BITS-1:0] dst_ff, dst_in;

   rso_rsp_type step_result;
   logic        take_ready;
   logic        req_xfer;

   assign req_chan.ready = take_ready;
   assign req_xfer       = req_chan.valid && take_ready;

   rso_step #(
      .ADDR_BITS (ADDR_BITS)
   ) u_step (
      .item          (req_chan.payload),
      .ctrl_cur      (ctrl_ff),
      .remaining_cur (remaining_ff),
      .acc_cur       (acc_ff),
      .src_cur       (src_ff),
      .dst_cur       (dst_ff),
      .ctrl_nxt      (ctrl_in),
      .remaining_nxt (remaining_in),
      .acc_nxt       (acc_in),
      .src_nxt       (src_in),
      .dst_nxt       (dst_in),
      .result        (step_result)
   );

   // advance state only on a request transfer; otherwise hold
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= '0;
         remaining_ff <= '0;
         acc_ff       <= '0;
         src_ff       <= '0;
         dst_ff       <= '0;
      end else if (req_xfer) begin
         ctrl_ff      <= ctrl_in;
         remaining_ff <= remaining_in;
         acc_ff       <= acc_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
      end
   end

   rso_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_xfer),
      .load_data (step_result),
      .in_ready  (take_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_chan.payload)
   );

endmodule

FILE: sv/rso_step.sv
// One-step next-state and result logic of the string operation engine.
module rso_step import rso_pkg::*; #(
   parameter int ADDR_BITS = 64
) (
   input  rso_req_type            item,
   input  rso_ctrl_type           ctrl_cur,
   input  logic [63:0]            remaining_cur,
   input  logic [63:0]            acc_cur,
   input  logic [ADDR_BITS-1:0]   src_cur,
   input  logic [ADDR_BITS-1:0]   dst_cur,
   output rso_ctrl_type           ctrl_nxt,
   output logic [63:0]            remaining_nxt,
   output logic [63:0]            acc_nxt,
   output logic [ADDR_BITS-1:0]   src_nxt,
   output logic [ADDR_BITS-1:0]   dst_nxt,
   output rso_rsp_type            result
);

   logic [63:0]          mask;
   logic [ADDR_BITS-1:0] step_amt;
   logic [ADDR_BITS-1:0] src_adv;
   logic [ADDR_BITS-1:0] dst_adv;
   logic [63:0]          rem_dec;
   logic [63:0]          diff;
   logic                 is_cmp;
   logic                 zf;
   logic                 done;
   logic                 flt;
   logic                 we;
   logic [63:0]          wa;
   logic [63:0]          wd;
   logic [1:0]           rep_eff;
   logic [63:0]          src_wide;
   logic [63:0]          dst_wide;
   logic [63:0]          dst_nxt_wide;

   assign mask     = size_mask(ctrl_cur.size);
   assign step_amt = ADDR_BITS'(4'b0001 << ctrl_cur.size);
   assign src_adv  = ctrl_cur.dir ? src_cur - step_amt : src_cur + step_amt;
   assign dst_adv  = ctrl_cur.dir ? dst_cur - step_amt : dst_cur + step_amt;
   assign rem_dec  = remaining_cur - 64'd1;
   assign rep_eff  = (item.rep_kind == REP_BAD) ? REP_NONE : item.rep_kind;

   always_comb begin
      ctrl_nxt      = ctrl_cur;
      remaining_nxt = remaining_cur;
      acc_nxt       = acc_cur;
      src_nxt       = src_cur;
      dst_nxt       = dst_cur;
      we            = 1'b0;
      wa            = '0;
      wd            = '0;
      diff          = '0;
      is_cmp        = 1'b0;
      zf            = 1'b0;
      done          = 1'b1;
      flt           = 1'b0;
      dst_wide      = '0;
      dst_wide[ADDR_BITS-1:0] = dst_cur;

      if (item.mode == MODE_BEGIN) begin
         ctrl_nxt.op   = item.op_kind;
         ctrl_nxt.size = item.size_code;
         ctrl_nxt.rep  = rep_eff;
         ctrl_nxt.dir  = item.direction;
         remaining_nxt = item.count;
         src_nxt       = item.src_addr[ADDR_BITS-1:0];
         dst_nxt       = item.dst_addr[ADDR_BITS-1:0];
         acc_nxt       = item.accumulator;
         done          = (item.op_kind > OP_CMPS) ||
                         ((rep_eff != REP_NONE) && (item.count == 64'd0));
         ctrl_nxt.busy = !done;
      end else if (!ctrl_cur.busy) begin
         done = 1'b1;
      end else if (item.fault) begin
         ctrl_nxt.busy = 1'b0;
         flt           = 1'b1;
      end else begin
         unique case (ctrl_cur.op)
            OP_MOVS: begin
               we      = 1'b1;
               wa      = dst_wide;
               wd      = item.src_data & mask;
               src_nxt = src_adv;
               dst_nxt = dst_adv;
            end
            OP_STOS: begin
               we      = 1'b1;
               wa      = dst_wide;
               wd      = acc_cur & mask;
               dst_nxt = dst_adv;
            end
            OP_LODS: begin
               if (ctrl_cur.size == SIZE_DWORD) begin
                  acc_nxt = item.src_data & mask;
               end else begin
                  acc_nxt = (acc_cur & ~mask) | (item.src_data & mask);
               end
               src_nxt = src_adv;
            end
            OP_SCAS: begin
               diff    = ((acc_cur & mask) - (item.dst_data & mask)) & mask;
               is_cmp  = 1'b1;
               dst_nxt = dst_adv;
            end
            default: begin
               diff    = ((item.src_data & mask) - (item.dst_data & mask)) & mask;
               is_cmp  = 1'b1;
               src_nxt = src_adv;
               dst_nxt = dst_adv;
            end
         endcase
         zf = is_cmp && (diff == 64'd0);
         if (ctrl_cur.rep != REP_NONE) begin
            remaining_nxt = rem_dec;
            done = (rem_dec == 64'd0) ||
                   (is_cmp && (ctrl_cur.rep == REP_E) && !zf) ||
                   (is_cmp && (ctrl_cur.rep == REP_NE) && zf);
         end else begin
            done = 1'b1;
         end
         if (done) begin
            ctrl_nxt.busy = 1'b0;
         end
      end
   end

   always_comb begin
      src_wide                = '0;
      src_wide[ADDR_BITS-1:0] = src_nxt;
   end

   always_comb begin
      dst_nxt_wide                = '0;
      dst_nxt_wide[ADDR_BITS-1:0] = dst_nxt;
   end

   always_comb begin
      result.write_enable = we;
      result.write_addr   = wa;
      result.write_data   = wd;
      result.next_src     = src_wide;
      result.next_dst     = dst_nxt_wide;
      result.count_left   = remaining_nxt;
      result.acc_value    = acc_nxt;
      result.difference   = diff;
      result.zero_flag    = zf;
      result.done_res     = done;
      result.faulted      = flt;
   end

endmodule

FILE: sv/rso_out_reg.sv
// Result register that holds a response until the receiver takes it.
module rso_out_reg import rso_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  rso_rsp_type load_data,
   output logic        in_ready,
   output logic        out_valid,
   input  logic        out_ready,
   output rso_rsp_type out_data
);

   logic        valid_ff;
   rso_rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= load;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

FILE: sv/rso_checker.sv
// Port-level assertions for the string operation engine, with its bind.
module rso_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_write_enable,
   input logic        rsp_zero_flag,
   input logic [63:0] rsp_difference,
   input logic        rsp_done,
   input logic        rsp_faulted
);

   // every request transfer shows a response in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("response missing after request transfer");

   // a held response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("request accepted while response stalled");

   // a fault ends the instruction and stores nothing
   a_fault_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_faulted) |-> (rsp_done && !rsp_write_enable))
      else $error("fault response without done or with a store");

   // stores come only from movs/stos, which compare nothing
   a_store_no_cmp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_write_enable) |-> (!rsp_zero_flag && rsp_difference == 64'd0))
      else $error("store response carries compare results");

   // response register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rep_string_op_engine rso_checker u_rso_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_write_enable (rsp_chan.payload.write_enable),
   .rsp_zero_flag    (rsp_chan.payload.zero_flag),
   .rsp_difference   (rsp_chan.payload.difference),
   .rsp_done         (rsp_chan.payload.done_res),
   .rsp_faulted      (rsp_chan.payload.faulted)
);

FILE: test/tb_rep_string_op_engine.sv
// Self-checking testbench for the x86 string operation engine.
module tb_rep_string_op_engine;
   import rso_pkg::*;

   localparam int ADDR_BITS = 64;
   // Operation code beyond CMPS; the engine must end such an instruction at once.
   localparam logic [2:0] OP_UNDEFINED = 3'd7;
   localparam int RANDOM_ITEMS = 1950;
   localparam int HOLD_CYCLES = 80;

   // Tracks the engine's architectural state and the responses it owes.
   class string_op_scoreboard;
      logic [2:0]  op;
      logic [1:0]  size;
      logic [1:0]  rep;
      logic        dir;
      logic [63:0] remaining;
      logic [63:0] src_ptr;
      logic [63:0] dst_ptr;
      logic [63:0] acc;
      bit          busy;
      logic [63:0] addr_mask;
      rso_rsp_type step_outcomes_q[$];
      int unsigned errors;
      int unsigned accepted;
      int unsigned ignored;
      int unsigned checked;
      int unsigned faults;
      int unsigned op_begins[8];

      function new(int addr_bits);
         addr_mask = (addr_bits >= 64) ? {64{1'b1}} : ((64'd1 << addr_bits) - 64'd1);
         op = OP_MOVS;
         size = SIZE_BYTE;
         rep = REP_NONE;
         dir = 1'b0;
         remaining = '0;
         src_ptr = '0;
         dst_ptr = '0;
         acc = '0;
         busy = 1'b0;
      endfunction

      static function logic [63:0] lane_mask(logic [1:0] s);
         return 64'hFFFF_FFFF_FFFF_FFFF >> (64 - (8 << s));
      endfunction

      function logic [63:0] step_addr(logic [63:0] a);
         logic [63:0] stride;
         stride = 64'd1 << size;
         return (dir ? a - stride : a + stride) & addr_mask;
      endfunction

      // Apply one accepted request and queue the response it must produce.
      function void execute_step(rso_req_type r);
         rso_rsp_type o;
         logic [63:0] m;
         bit          cmp;
         o = '0;
         cmp = 1'b0;
         accepted++;
         if (r.mode == MODE_BEGIN) begin
            op = r.op_kind;
            size = r.size_code;
            rep = (r.rep_kind == REP_BAD) ? REP_NONE : r.rep_kind;
            dir = r.direction;
            remaining = r.count;
            src_ptr = r.src_addr & addr_mask;
            dst_ptr = r.dst_addr & addr_mask;
            acc = r.accumulator;
            op_begins[op]++;
            o.done_res = (op > OP_CMPS) || (rep != REP_NONE && remaining == 0);
            busy = !o.done_res;
         end else if (!busy) begin
            ignored++;
            o.done_res = 1'b1;
         end else if (r.fault) begin
            faults++;
            busy = 1'b0;
            o.done_res = 1'b1;
            o.faulted = 1'b1;
         end else begin
            m = lane_mask(size);
            case (op)
               OP_MOVS: begin
                  o.write_enable = 1'b1;
                  o.write_addr = dst_ptr;
                  o.write_data = r.src_data & m;
                  src_ptr = step_addr(src_ptr);
                  dst_ptr = step_addr(dst_ptr);
               end
               OP_STOS: begin
                  o.write_enable = 1'b1;
                  o.write_addr = dst_ptr;
                  o.write_data = acc & m;
                  dst_ptr = step_addr(dst_ptr);
               end
               OP_LODS: begin
                  // dword loads zero-extend, the others merge into the low lanes
                  if (size == SIZE_DWORD)
                     acc = r.src_data & m;
                  else
                     acc = (acc & ~m) | (r.src_data & m);
                  src_ptr = step_addr(src_ptr);
               end
               OP_SCAS: begin
                  o.difference = ((acc & m) - (r.dst_data & m)) & m;
                  cmp = 1'b1;
                  dst_ptr = step_addr(dst_ptr);
               end
               default: begin
                  o.difference = ((r.src_data & m) - (r.dst_data & m)) & m;
                  cmp = 1'b1;
                  src_ptr = step_addr(src_ptr);
                  dst_ptr = step_addr(dst_ptr);
               end
            endcase
            if (cmp)
               o.zero_flag = (o.difference == '0);
            if (rep != REP_NONE) begin
               remaining = remaining - 64'd1;
               o.done_res = (remaining == '0);
               if (cmp && rep == REP_E && !o.zero_flag)
                  o.done_res = 1'b1;
               if (cmp && rep == REP_NE && o.zero_flag)
                  o.done_res = 1'b1;
            end else begin
               o.done_res = 1'b1;
            end
            if (o.done_res)
               busy = 1'b0;
         end
         o.next_src = src_ptr;
         o.next_dst = dst_ptr;
         o.count_left = remaining;
         o.acc_value = acc;
         step_outcomes_q.push_back(o);
      endfunction

      function void compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s mismatch: expected %h actual %h", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(rso_rsp_type a);
         rso_rsp_type e;
         if (step_outcomes_q.size() == 0) begin
            $error("response transfer with no request outstanding");
            errors++;
            return;
         end
         e = step_outcomes_q.pop_front();
         checked++;
         compare_field("write_enable", 64'(e.write_enable), 64'(a.write_enable));
         compare_field("write_addr", e.write_addr, a.write_addr);
         compare_field("write_data", e.write_data, a.write_data);
         compare_field("next_src", e.next_src, a.next_src);
         compare_field("next_dst", e.next_dst, a.next_dst);
         compare_field("count_left", e.count_left, a.count_left);
         compare_field("acc_value", e.acc_value, a.acc_value);
         compare_field("difference", e.difference, a.difference);
         compare_field("zero_flag", 64'(e.zero_flag), 64'(a.zero_flag));
         compare_field("done_res", 64'(e.done_res), 64'(a.done_res));
         compare_field("faulted", 64'(e.faulted), 64'(a.faulted));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   rso_req_if req_chan ();
   rso_rsp_if rsp_chan ();

   string_op_scoreboard engine_ledger;

   // Idle rates in percent, retuned per phase of the run.
   int  send_idle_pct = 27;
   int  recv_idle_pct = 73;
   int  run_phase = 0;
   logic hold_rsp;

   rep_string_op_engine #(
      .ADDR_BITS(ADDR_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Bias some addresses toward the ends of the space so stepping wraps.
   function automatic logic [63:0] pick_addr();
      int p;
      p = $urandom_range(99);
      if (p < 8)
         return 64'($urandom_range(7));
      else if (p < 15)
         return ~64'($urandom_range(7));
      return rand64();
   endfunction

   // Offer one request, idling at random first, and hold it until transfer.
   // Ready is sampled at the edge, before the engine updates, so the
   // handshake seen here is the one the engine sees.
   task automatic send_item(input rso_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
      engine_ledger.execute_step(r);
   endtask

   // Load a new instruction; the data fields carry noise.
   task automatic begin_item(input logic [2:0] op, input logic [1:0] size,
                             input logic [1:0] rep, input logic dir,
                             input logic [63:0] cnt, input logic [63:0] src,
                             input logic [63:0] dst, input logic [63:0] acc);
      rso_req_type r;
      r.mode = MODE_BEGIN;
      r.op_kind = op;
      r.size_code = size;
      r.rep_kind = rep;
      r.direction = dir;
      r.count = cnt;
      r.src_addr = src;
      r.dst_addr = dst;
      r.accumulator = acc;
      r.src_data = rand64();
      r.dst_data = rand64();
      r.fault = 1'($urandom_range(1));
      send_item(r);
   endtask

   // Deliver one iteration's memory words; the begin-only fields carry noise.
   task automatic data_item(input logic [63:0] sd, input logic [63:0] dd, input logic flt);
      rso_req_type r;
      r.mode = MODE_DATA;
      r.op_kind = 3'($urandom_range(7));
      r.size_code = 2'($urandom_range(3));
      r.rep_kind = 2'($urandom_range(3));
      r.direction = 1'($urandom_range(1));
      r.count = rand64();
      r.src_addr = rand64();
      r.dst_addr = rand64();
      r.accumulator = rand64();
      r.src_data = sd;
      r.dst_data = dd;
      r.fault = flt;
      send_item(r);
   endtask

   // Hand-picked instructions covering wrap, every operation and the corner cases.
   task automatic run_directed();
      // byte MOVS with REP, source wraps past the top of the address space
      begin_item(OP_MOVS, SIZE_BYTE, REP_E, 1'b0, 64'd2, {64{1'b1}},
                 64'hFFFF_FFFF_FFFF_FFFE, '0);
      data_item({64{1'b1}}, '0, 1'b0);
      data_item('0, {64{1'b1}}, 1'b0);
      // qword STOS stepping down from zero
      begin_item(OP_STOS, SIZE_QWORD, REP_E, 1'b1, 64'd1, '0, '0, {64{1'b1}});
      data_item(rand64(), rand64(), 1'b0);
      // dword LODS without prefix: zero-extends, count untouched
      begin_item(OP_LODS, SIZE_DWORD, REP_NONE, 1'b0, 64'd7, rand64(), rand64(), {64{1'b1}});
      data_item(64'h0123_4567_89AB_CDEF, rand64(), 1'b0);
      // word LODS with the unknown prefix code acts as a single pass
      begin_item(OP_LODS, SIZE_WORD, REP_BAD, 1'b1, 64'd3, rand64(), rand64(),
                 64'hA5A5_A5A5_A5A5_A5A5);
      data_item({64{1'b1}}, rand64(), 1'b0);
      // REPE SCAS: match continues, mismatch stops, then data while idle
      begin_item(OP_SCAS, SIZE_BYTE, REP_E, 1'b0, 64'd3, rand64(), rand64(),
                 64'h1234_5678_9ABC_DE41);
      data_item(rand64(), 64'hFFFF_FFFF_FFFF_FF41, 1'b0);
      data_item(rand64(), 64'h0000_0000_0000_0042, 1'b0);
      data_item(rand64(), rand64(), 1'b0);
      // REPNE CMPS with the largest count: mismatch continues, match stops
      begin_item(OP_CMPS, SIZE_QWORD, REP_NE, 1'b1, {64{1'b1}}, {64{1'b1}}, '0, rand64());
      data_item(64'd1, 64'd2, 1'b0);
      data_item({64{1'b1}}, {64{1'b1}}, 1'b0);
      // prefixed with zero count and an undefined operation both end at once
      begin_item(OP_MOVS, SIZE_WORD, REP_E, 1'b0, '0, rand64(), rand64(), rand64());
      begin_item(OP_UNDEFINED, SIZE_BYTE, REP_NONE, 1'b0, 64'd5, rand64(), rand64(),
                 rand64());
      // fault ends the instruction; the next data item is ignored
      begin_item(OP_MOVS, SIZE_WORD, REP_E, 1'b0, 64'd4, rand64(), rand64(), rand64());
      data_item(rand64(), rand64(), 1'b1);
      data_item(rand64(), rand64(), 1'b0);
      // begin while busy abandons the running instruction
      begin_item(OP_STOS, SIZE_DWORD, REP_E, 1'b1, 64'd3, rand64(), rand64(), rand64());
      data_item(rand64(), rand64(), 1'b0);
      begin_item(OP_CMPS, SIZE_BYTE, REP_NONE, 1'b0, 64'd9, rand64(), rand64(), rand64());
      data_item(64'h55, 64'h55, 1'b0);
      // REPNE on LODS ignores the zero flag and runs the count out
      begin_item(OP_LODS, SIZE_QWORD, REP_NE, 1'b0, 64'd2, rand64(), rand64(), '0);
      data_item('0, rand64(), 1'b0);
      data_item(rand64(), rand64(), 1'b0);
   endtask

   // One instruction with random content, mostly well formed.
   task automatic issue_random_sequence();
      logic [2:0]  op;
      logic [1:0]  size;
      logic [1:0]  rep;
      logic        dir;
      logic [63:0] cnt;
      logic [63:0] acc;
      logic [63:0] m;
      logic [63:0] sd;
      logic [63:0] dd;
      logic [63:0] base;
      int          n;
      int          p;
      int          eq_pct;
      bit          repeats;
      // drop in a stray item now and then
      if ($urandom_range(99) < 5) begin
         if ($urandom_range(1))
            data_item(rand64(), rand64(), 1'($urandom_range(1)));
         else
            begin_item(3'($urandom_range(7)), 2'($urandom_range(3)), 2'($urandom_range(3)),
                       1'($urandom_range(1)), rand64(), rand64(), rand64(), rand64());
         return;
      end
      op = ($urandom_range(99) < 3) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      p = $urandom_range(99);
      rep = (p < 20) ? REP_NONE : (p < 65) ? REP_E : (p < 90) ? REP_NE : REP_BAD;
      p = $urandom_range(99);
      cnt = (p < 5) ? '0 : (p < 15) ? rand64() : (p < 20) ? {64{1'b1}} :
            64'($urandom_range(6, 1));
      size = 2'($urandom_range(3));
      dir = 1'($urandom_range(1));
      acc = rand64();
      begin_item(op, size, rep, dir, cnt, pick_addr(), pick_addr(), acc);

      repeats = (rep == REP_E || rep == REP_NE);
      if (op > OP_CMPS || (repeats && cnt == '0))
         n = $urandom_range(1);
      else if (!repeats)
         n = 1;
      else if (cnt > 64'd6)
         n = $urandom_range(8, 1);
      else begin
         // occasionally overrun or cut short the count
         p = $urandom_range(99);
         n = int'(cnt) + ((p < 10) ? 1 : (p < 20) ? -1 : 0);
      end

      m = string_op_scoreboard::lane_mask(size);
      eq_pct = (rep == REP_E) ? 85 : (rep == REP_NE) ? 30 : 50;
      for (int i = 0; i < n; i++) begin
         sd = rand64();
         base = (op == OP_SCAS) ? acc : sd;
         dd = ($urandom_range(99) < eq_pct) ? ((base & m) | (rand64() & ~m)) : rand64();
         data_item(sd, dd, $urandom_range(99) < 3);
      end
   endtask

   // Response side: check every transfer, then pick the next ready.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready)
            engine_ledger.check_response(rsp_chan.payload);
         rsp_chan.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Hold off the response side for a long stretch once the last phase begins,
   // so the result register fills and the engine stalls its input.
   initial begin
      hold_rsp <= 1'b0;
      wait (run_phase == 2);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Watchdog: end the run if traffic stops making progress.
   initial begin
      #3_000_000;
      $display("tb_rep_string_op_engine NOT OK");
      $finish;
   end

   initial begin
      int random_base;
      int progress;
      engine_ledger = new(ADDR_BITS);
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Three phases: sender idles less than receiver, then the reverse, then
      // neither idles. Items ignored by an idle engine do not advance progress.
      random_base = engine_ledger.accepted - engine_ledger.ignored;
      progress = 0;
      while (progress < RANDOM_ITEMS) begin
         run_phase = (progress * 3) / RANDOM_ITEMS;
         case (run_phase)
            0: begin
               send_idle_pct = 27;
               recv_idle_pct = 73;
            end
            1: begin
               send_idle_pct = 73;
               recv_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         issue_random_sequence();
         progress = engine_ledger.accepted - engine_ledger.ignored - random_base;
      end
      req_chan.valid <= 1'b0;

      // Drain, then allow a few extra cycles to catch any stray response.
      while (engine_ledger.step_outcomes_q.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d request transfers (%0d ignored while idle, %0d faults),",
               engine_ledger.accepted, engine_ledger.ignored, engine_ledger.faults);
      $display("%0d responses checked; instructions begun: movs %0d stos %0d lods %0d scas %0d cmps %0d.",
               engine_ledger.checked,
               engine_ledger.op_begins[OP_MOVS], engine_ledger.op_begins[OP_STOS],
               engine_ledger.op_begins[OP_LODS], engine_ledger.op_begins[OP_SCAS],
               engine_ledger.op_begins[OP_CMPS]);
      if (engine_ledger.errors == 0 && engine_ledger.step_outcomes_q.size() == 0)
         $display("tb_rep_string_op_engine OK");
      else
         $display("tb_rep_string_op_engine NOT OK");
      $finish;
   end

endmodule
